/* src/speed_frame_parser_unit_defines.svh */
// Assertion macros used by the checker file of the frame parser.
`ifndef SPEED_FRAME_PARSER_UNIT_DEFINES_SVH
`define SPEED_FRAME_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfp_checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfp_checker: next-cycle property failed");

`endif

/* src/sfp_pkg.sv */
package sfp_pkg;

   localparam logic [7:0] HDR_FIRST    = 8'hAA;
   localparam logic [7:0] HDR_SECOND   = 8'h55;
   localparam logic [7:0] TRAILER_BYTE = 8'hBF;

   localparam logic [3:0] POS_FIRST_DATA = 4'd4;
   localparam logic [3:0] POS_STAMP_0    = 4'd4;
   localparam logic [3:0] POS_STAMP_1    = 4'd5;
   localparam logic [3:0] POS_STAMP_2    = 4'd6;
   localparam logic [3:0] POS_STAMP_3    = 4'd7;
   localparam logic [3:0] POS_SPEED_HI   = 4'd8;
   localparam logic [3:0] POS_SPEED_LO   = 4'd9;
   localparam logic [3:0] POS_MAX        = 4'd15;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_SOURCE  = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_DATA    = 3'd4,
      PH_TRAILER = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]  source_id;
      logic [7:0]  payload_length;
      logic [31:0] time_stamp;
      logic [15:0] speed_value;
   } result_type;

endpackage

/* src/speed_frame_parser_unit.sv */
// Byte-serial parser for length-prefixed speed report frames.
// The req channel carries one received byte per item on req_rx_byte. The
// parser hunts for the header 0xAA 0x55, then takes a source byte, a length
// byte, at least one data byte and the trailer 0xBF. Any byte that breaks
// this pattern sends it back to hunting without a result.
// Frame bytes 4 to 7 form a big-endian time stamp and bytes 8 and 9 a
// big-endian speed; bytes a short frame does not reach keep old values.
// Each good trailer produces one item on the rsp channel with the source,
// length, time stamp and speed of the frame.
// A byte is registered in the input register when it is accepted and is
// parsed from there; a good trailer loads its result into the result
// register, which drives rsp_valid and the rsp data ports.
// One byte can be accepted every cycle while req_stall is low.
// When rsp_stall holds a waiting result, bytes that produce no result keep
// flowing; a second trailer waits in the input register and req_stall rises.
// Reset is synchronous and clears the parser, its capture registers and both
// valid flags, not the byte or result data; req_stall is high during reset.
module speed_frame_parser_unit
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_source_id,
   output logic [7:0]  rsp_payload_length,
   output logic [31:0] rsp_time_stamp,
   output logic [15:0] rsp_speed_value
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       hit;
   logic       advance;
   logic       accept;
   result_type result;

   assign advance     = in_valid_ff & (~hit | ~rsp_valid | ~rsp_stall);
   assign req_stall   = reset | (in_valid_ff & ~advance);
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .hit     (hit),
      .result  (result)
   );

   sfp_result_reg u_result (
      .clock              (clock),
      .reset              (reset),
      .load               (advance & hit),
      .result             (result),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_source_id      (rsp_source_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_speed_value    (rsp_speed_value)
   );

endmodule

/* src/sfp_parser.sv */
module sfp_parser
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       hit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  source_ff, source_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [15:0] speed_ff, speed_in;
   logic [7:0]  count_inc;
   logic        capture;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == HDR_FIRST) begin
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (rx_byte == HDR_SECOND) begin
               phase_in = PH_SOURCE;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_SOURCE: begin
            phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            phase_in = PH_DATA;
         end
         PH_DATA: begin
            if (count_inc >= len_ff) begin
               phase_in = PH_TRAILER;
            end
         end
         PH_TRAILER: begin
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      source_in = source_ff;
      capture   = 1'b0;
      hit       = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte != HDR_FIRST) begin
               pos_in = '0;
               len_in = '0;
            end
         end
         PH_HDR2: begin
            if (rx_byte != HDR_SECOND) begin
               pos_in = '0;
               len_in = '0;
            end
         end
         PH_SOURCE: begin
            source_in = rx_byte;
         end
         PH_LENGTH: begin
            len_in = rx_byte;
            pos_in = POS_FIRST_DATA;
         end
         PH_DATA: begin
            capture = 1'b1;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 4'd1;
            end
            if (count_inc >= len_ff) begin
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_TRAILER: begin
            if (rx_byte == TRAILER_BYTE) begin
               capture = 1'b1;
               hit     = 1'b1;
            end
            pos_in = '0;
            len_in = '0;
         end
         default: begin
            pos_in = '0;
            len_in = '0;
         end
      endcase
   end

   always_comb begin
      stamp_in = stamp_ff;
      speed_in = speed_ff;
      if (capture) begin
         case (pos_ff)
            POS_STAMP_0:  stamp_in[31:24] = rx_byte;
            POS_STAMP_1:  stamp_in[23:16] = rx_byte;
            POS_STAMP_2:  stamp_in[15:8]  = rx_byte;
            POS_STAMP_3:  stamp_in[7:0]   = rx_byte;
            POS_SPEED_HI: speed_in[15:8]  = rx_byte;
            POS_SPEED_LO: speed_in[7:0]   = rx_byte;
            default: begin
               stamp_in = stamp_ff;
               speed_in = speed_ff;
            end
         endcase
      end
   end

   assign result.source_id      = source_ff;
   assign result.payload_length = len_ff;
   assign result.time_stamp     = stamp_in;
   assign result.speed_value    = speed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         pos_ff    <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         source_ff <= '0;
         stamp_ff  <= '0;
         speed_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         source_ff <= source_in;
         stamp_ff  <= stamp_in;
         speed_ff  <= speed_in;
      end
   end

endmodule

/* src/sfp_result_reg.sv */
module sfp_result_reg
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_source_id,
   output logic [7:0]  rsp_payload_length,
   output logic [31:0] rsp_time_stamp,
   output logic [15:0] rsp_speed_value
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_source_id      = data_ff.source_id;
   assign rsp_payload_length = data_ff.payload_length;
   assign rsp_time_stamp     = data_ff.time_stamp;
   assign rsp_speed_value    = data_ff.speed_value;

endmodule

/* src/sfp_checker.sv */
`include "speed_frame_parser_unit_defines.svh"

module sfp_checker
   import sfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_source_id,
   input logic [7:0]  rsp_payload_length,
   input logic [31:0] rsp_time_stamp,
   input logic [15:0] rsp_speed_value
);

   // A new result must follow an accepted trailer byte.
   `SFP_ASSERT_NOW(a_rise_after_trailer, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_rx_byte == TRAILER_BYTE, 2))

   // Reset leaves no result pending.
   `SFP_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

   // Nothing is taken on the req side while reset is applied.
   `SFP_ASSERT_NOW(a_stall_in_reset, clock, 1'b0, reset, req_stall)

   // A stalled result stays in place with all of its fields.
   `SFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_source_id) && $stable(rsp_payload_length) && $stable(rsp_time_stamp) && $stable(rsp_speed_value))

endmodule

bind speed_frame_parser_unit sfp_checker u_sfp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_rx_byte        (req_rx_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_source_id      (rsp_source_id),
   .rsp_payload_length (rsp_payload_length),
   .rsp_time_stamp     (rsp_time_stamp),
   .rsp_speed_value    (rsp_speed_value)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import sfp_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int MAX_WAIT   = 12;
   localparam int LONG_HOLD  = 400;
   localparam int DRAIN      = 16;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_source_id;
   logic [7:0]  rsp_payload_length;
   logic [31:0] rsp_time_stamp;
   logic [15:0] rsp_speed_value;

   phase_type   frame_phase;
   logic [3:0]  frame_pos;
   logic [7:0]  frame_length;
   logic [7:0]  data_seen;
   logic [7:0]  frame_source;
   logic [31:0] frame_stamp;
   logic [15:0] frame_speed;

   result_type  pending_reports[$];
   result_type  want_report;
   logic [7:0]  frame_bytes[$];

   int error_count    = 0;
   int idle_cycles    = 0;
   int rsp_wait       = 0;
   int hold_left      = 0;
   bit sender_quiet   = 1'b0;
   bit receiver_quiet = 1'b0;

   speed_frame_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_source_id      (rsp_source_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_speed_value    (rsp_speed_value)
   );

   always #5 clock = ~clock;

   function automatic void capture_frame_byte(input logic [3:0] at, input logic [7:0] b);
      case (at)
         POS_STAMP_0:  frame_stamp[31:24] = b;
         POS_STAMP_1:  frame_stamp[23:16] = b;
         POS_STAMP_2:  frame_stamp[15:8]  = b;
         POS_STAMP_3:  frame_stamp[7:0]   = b;
         POS_SPEED_HI: frame_speed[15:8]  = b;
         POS_SPEED_LO: frame_speed[7:0]   = b;
         default: ;
      endcase
   endfunction

   function automatic void restart_hunt();
      frame_phase  = PH_HUNT;
      frame_pos    = 4'd0;
      frame_length = 8'd0;
   endfunction

   function automatic void track_frame_byte(input logic [7:0] b);
      if (frame_phase == PH_HUNT && b == HDR_FIRST) begin
         frame_phase = PH_HDR2;
      end else if (frame_phase == PH_HDR2 && b == HDR_SECOND) begin
         frame_phase = PH_SOURCE;
      end else if (frame_phase == PH_SOURCE) begin
         frame_source = b;
         frame_phase  = PH_LENGTH;
      end else if (frame_phase == PH_LENGTH) begin
         frame_length = b;
         frame_pos    = POS_FIRST_DATA;
         frame_phase  = PH_DATA;
      end else if (frame_phase == PH_DATA) begin
         capture_frame_byte(frame_pos, b);
         if (frame_pos != POS_MAX) begin
            frame_pos = frame_pos + 4'd1;
         end
         data_seen = data_seen + 8'd1;
         if (data_seen >= frame_length) begin
            data_seen   = 8'd0;
            frame_phase = PH_TRAILER;
         end
      end else if (frame_phase == PH_TRAILER && b == TRAILER_BYTE) begin
         capture_frame_byte(frame_pos, b);
         pending_reports.push_back('{frame_source, frame_length, frame_stamp, frame_speed});
         restart_hunt();
      end else begin
         restart_hunt();
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      track_frame_byte(b);
   endtask

   task automatic send_frame_bytes();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
      end
      frame_bytes.delete();
   endtask

   task automatic queue_frame(input logic [7:0] src, input logic [7:0] len);
      int count;
      count = (len == 8'd0) ? 1 : len;
      frame_bytes.push_back(HDR_FIRST);
      frame_bytes.push_back(HDR_SECOND);
      frame_bytes.push_back(src);
      frame_bytes.push_back(len);
      repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(TRAILER_BYTE);
   endtask

   task automatic test_basic_frames();
      frame_bytes = '{HDR_FIRST, HDR_SECOND, 8'hFF, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, TRAILER_BYTE};
      send_frame_bytes();
      // A zero length still takes one data byte, and the trailer lands in the stamp.
      frame_bytes = '{HDR_FIRST, HDR_SECOND, 8'h00, 8'h00, 8'h00, TRAILER_BYTE};
      send_frame_bytes();
   endtask

   task automatic test_broken_patterns();
      frame_bytes = '{HDR_FIRST, HDR_FIRST, HDR_SECOND};
      send_frame_bytes();
      frame_bytes = '{HDR_FIRST, HDR_SECOND, 8'h01, 8'h00, 8'h07, 8'h11};
      send_frame_bytes();
   endtask

   task automatic test_long_frames();
      queue_frame(8'($urandom_range(0, 255)), 8'hFF);
      send_frame_bytes();
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(128, 254)));
      send_frame_bytes();
   endtask

   task automatic test_output_backpressure();
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      hold_left      = LONG_HOLD;
      repeat (20) begin
         queue_frame(8'($urandom_range(0, 255)), 8'd0);
         send_frame_bytes();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      int sent;
      int kind;
      int at;
      logic [7:0] len;
      sent = 0;
      while (sent < 650) begin
         if ($urandom_range(0, 9) == 0) begin
            sender_quiet   = !sender_quiet;
            receiver_quiet = 1'($urandom_range(0, 1));
         end
         kind = $urandom_range(0, 9);
         len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(11, 40))
                                            : 8'($urandom_range(0, 10));
         queue_frame(8'($urandom_range(0, 255)), len);
         if (kind == 8) begin
            at = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[at] = frame_bytes[at] ^ 8'($urandom_range(1, 255));
         end else if (kind == 9) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         sent += frame_bytes.size();
         send_frame_bytes();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      frame_phase = PH_HUNT;
      frame_pos    = 4'd0;
      frame_length = 8'd0;
      data_seen    = 8'd0;
      frame_source = 8'd0;
      frame_stamp  = 32'd0;
      frame_speed  = 16'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_frames();
      test_broken_patterns();
      test_long_frames();
      test_output_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report: source_id %0h payload_length %0h",
                   rsp_source_id, rsp_payload_length);
            error_count++;
         end else begin
            want_report = pending_reports.pop_front();
            if (rsp_source_id !== want_report.source_id) begin
               $error("source_id expected %0h actual %0h",
                      want_report.source_id, rsp_source_id);
               error_count++;
            end
            if (rsp_payload_length !== want_report.payload_length) begin
               $error("payload_length expected %0h actual %0h",
                      want_report.payload_length, rsp_payload_length);
               error_count++;
            end
            if (rsp_time_stamp !== want_report.time_stamp) begin
               $error("time_stamp expected %0h actual %0h",
                      want_report.time_stamp, rsp_time_stamp);
               error_count++;
            end
            if (rsp_speed_value !== want_report.speed_value) begin
               $error("speed_value expected %0h actual %0h",
                      want_report.speed_value, rsp_speed_value);
               error_count++;
            end
         end
         rsp_wait = receiver_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
